// File: rtl/core/rtf_pkg.sv
// Shared constants, types and the colour palette of the RGB colour fade block.
`default_nettype none

package rtf_pkg;

    localparam int PaletteRows  = 14;
    localparam int PaletteSize  = 14;
    localparam int SmallDiff    = 20;
    localparam int SnapDist     = 13;
    // mag / 20 == (mag * 205) >> 12 for every 8-bit mag.
    localparam int RecipMul     = 205;
    localparam int RecipShift   = 12;

    // Per-channel update controls for one item.
    typedef struct packed {
        logic sel_upd;   // valid colour select taken this cycle
        logic first;     // no colour has been selected since reset
        logic tick;      // tick taken this cycle after the first select
    } t_chan_ctl;

    // Palette row as {red, green, blue}.
    function automatic logic [23:0] rtf_palette(input logic [3:0] idx);
        logic [23:0] rgb;
        case (idx)
            4'd0:    rgb = {8'd255, 8'd0,   8'd0};
            4'd1:    rgb = {8'd0,   8'd255, 8'd0};
            4'd2:    rgb = {8'd0,   8'd0,   8'd255};
            4'd3:    rgb = {8'd255, 8'd255, 8'd0};
            4'd4:    rgb = {8'd255, 8'd0,   8'd255};
            4'd5:    rgb = {8'd0,   8'd255, 8'd255};
            4'd6:    rgb = {8'd255, 8'd255, 8'd255};
            4'd7:    rgb = {8'd255, 8'd39,  8'd0};
            4'd8:    rgb = {8'd255, 8'd0,   8'd39};
            4'd9:    rgb = {8'd20,  8'd255, 8'd0};
            4'd10:   rgb = {8'd0,   8'd255, 8'd39};
            4'd11:   rgb = {8'd20,  8'd0,   8'd255};
            4'd12:   rgb = {8'd0,   8'd39,  8'd255};
            4'd13:   rgb = {8'd158, 8'd39,  8'd255};
            default: rgb = 24'd0;
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rtf_chan.sv
// One colour channel: target, step and duty registers with their update logic.
`default_nettype none

module rtf_chan
    import rtf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_chan_ctl  i_ctl,
    input  wire logic [7:0] i_new_target,
    output logic      [7:0] o_duty,
    output logic      [7:0] o_duty_next,
    output logic            o_settled_next
);

    logic        [7:0]  r_target, n_target;
    logic signed [4:0]  r_step,   n_step;
    logic        [7:0]  r_duty,   n_duty;

    logic signed [8:0]  w_diff;
    logic        [7:0]  w_mag;
    logic        [15:0] w_prod;
    logic        [4:0]  w_step_mag;
    logic signed [4:0]  w_new_step;
    logic        [7:0]  w_sum;
    logic        [7:0]  w_dist;
    logic               w_snap;

    // Step from the change of target; the divide by twenty is a reciprocal multiply.
    always_comb begin
        w_diff = $signed({1'b0, i_new_target}) - $signed({1'b0, r_target});
        w_mag  = w_diff[8] ? 8'(-w_diff) : w_diff[7:0];
        w_prod = w_mag * 8'(RecipMul);
        if (w_mag <= 8'(SmallDiff)) begin
            w_step_mag = 5'd1;
        end else begin
            w_step_mag = {1'b0, w_prod[RecipShift +: 4]} + 5'd1;
        end
        if (w_diff == 9'sd0) begin
            w_new_step = r_step;
        end else if (w_diff[8]) begin
            w_new_step = -$signed(w_step_mag);
        end else begin
            w_new_step = $signed(w_step_mag);
        end
    end

    // Tick: add the step with 8-bit wrap, then snap when close enough.
    always_comb begin
        w_sum  = r_duty + {{3{r_step[4]}}, r_step};
        w_dist = (w_sum >= r_target) ? (w_sum - r_target) : (r_target - w_sum);
        w_snap = (w_dist <= 8'(SnapDist));
    end

    always_comb begin
        n_target = r_target;
        n_step   = r_step;
        n_duty   = r_duty;
        if (i_ctl.sel_upd) begin
            n_target = i_new_target;
            if (i_ctl.first) begin
                n_duty = i_new_target;
            end else begin
                n_step = w_new_step;
            end
        end else if (i_ctl.tick && (r_duty != r_target)) begin
            n_duty = w_snap ? r_target : w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= 8'd0;
            r_step   <= 5'sd0;
            r_duty   <= 8'd0;
        end else begin
            r_target <= n_target;
            r_step   <= n_step;
            r_duty   <= n_duty;
        end
    end

    assign o_duty         = r_duty;
    assign o_duty_next    = n_duty;
    assign o_settled_next = (n_duty == n_target);

endmodule

`default_nettype wire

// File: rtl/core/rgb_tick_color_fade_core.sv
// Top level of the RGB colour fade block: input register, channel updates, result register.
`default_nettype none

// Fades three 8-bit PWM duties toward palette colours. Each accepted item (a tick or a
// colour select) yields exactly one result carrying the duties after that item and a
// settled flag. An item passes an input register and then the per-channel update logic
// into the result register. One item is taken every cycle unless the downstream stall
// holds the flow; that stall is the only limit on rate, and the input register absorbs
// it for one item. Selects with an index outside the palette leave the state unchanged.
module rgb_tick_color_fade_core
    import rtf_pkg::*;
#(
    parameter int PALETTE_SIZE = PaletteSize
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_opcode,
    input  wire logic [3:0] i_color_index,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic      [7:0] o_duty_red,
    output logic      [7:0] o_duty_green,
    output logic      [7:0] o_duty_blue,
    output logic            o_settled
);

    logic       r_in_valid;
    logic       r_op;
    logic [3:0] r_idx;
    logic       r_started, n_started;
    logic       r_out_valid;

    logic        w_adv;
    logic        w_fire;
    logic        w_sel_ok;
    logic [23:0] w_rgb;
    t_chan_ctl   w_ctl;

    logic [7:0] w_duty_r, w_duty_g, w_duty_b;
    logic [7:0] w_next_r, w_next_g, w_next_b;
    logic       w_set_r, w_set_g, w_set_b;

    // The result register frees up when it is empty or being taken.
    assign w_adv   = !r_out_valid || !i_stall;
    assign w_fire  = r_in_valid && w_adv;
    assign o_stall = r_in_valid && !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_op  <= i_opcode;
            r_idx <= i_color_index;
        end
    end

    assign w_rgb    = rtf_palette(r_idx);
    assign w_sel_ok = r_op && (32'(r_idx) < PALETTE_SIZE) && (32'(r_idx) < PaletteRows);

    always_comb begin
        w_ctl.sel_upd = w_fire && w_sel_ok;
        w_ctl.first   = !r_started;
        w_ctl.tick    = w_fire && !r_op && r_started;
        n_started     = r_started || w_ctl.sel_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
        end else begin
            r_started <= n_started;
        end
    end

    rtf_chan u_chan_red (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_new_target   (w_rgb[23:16]),
        .o_duty         (w_duty_r),
        .o_duty_next    (w_next_r),
        .o_settled_next (w_set_r)
    );

    rtf_chan u_chan_green (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_new_target   (w_rgb[15:8]),
        .o_duty         (w_duty_g),
        .o_duty_next    (w_next_g),
        .o_settled_next (w_set_g)
    );

    rtf_chan u_chan_blue (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_new_target   (w_rgb[7:0]),
        .o_duty         (w_duty_b),
        .o_duty_next    (w_next_b),
        .o_settled_next (w_set_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            o_duty_red   <= w_next_r;
            o_duty_green <= w_next_g;
            o_duty_blue  <= w_next_b;
            o_settled    <= w_set_r && w_set_g && w_set_b;
        end
    end

    assign o_valid = r_out_valid;

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled without a held item and a blocked result");

    a_item_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("held item did not reach the free result register");

    a_idle_before_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_started |-> (w_duty_r == 8'd0 && w_duty_g == 8'd0 && w_duty_b == 8'd0))
        else $error("duty moved before the first colour select");

    a_started_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |=> r_started)
        else $error("started flag cleared outside reset");

endmodule

`default_nettype wire
